// ===== rtl/npcm_pkg.sv =====
// Types, constants and the distance function shared by the palette mapper modules.
package npcm_pkg;

  // Channel bytes carried by a pixel or a palette entry.
  localparam int NUM_CHAN = 4;
  localparam int CHAN_W = 8;

  // Squared distance over at most four channels fits in 18 bits.
  localparam int DIST_W = 18;

  // Palette index inside the chain; covers the largest supported depth.
  localparam int IDX_W = 8;

  // Item operation codes.
  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Input item: a pixel to map or a palette entry to load.
  typedef struct packed {
    logic       opcode;
    logic [3:0] entry_index;
    logic [7:0] chan_0;
    logic [7:0] chan_1;
    logic [7:0] chan_2;
    logic [7:0] chan_3;
    logic       selected;
    logic       frame_end;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_chan_0;
    logic [7:0] out_chan_1;
    logic [7:0] out_chan_2;
    logic [7:0] out_chan_3;
    logic [3:0] chosen_index;
    logic       written;
    logic       frame_end_out;
  } out_item_t;

  // What travels from one cell to the next: the item and the best match so far.
  typedef struct packed {
    logic             valid;
    in_item_t         item;
    dist_t            best_d;
    logic [IDX_W-1:0] best_idx;
    color_t           best_color;
  } flow_t;

  // Gather the channel bytes of an item into one color word.
  function automatic color_t item_color(in_item_t it);
    color_t c;
    c[0] = it.chan_0;
    c[1] = it.chan_1;
    c[2] = it.chan_2;
    c[3] = it.chan_3;
    return c;
  endfunction

  // Sum of squared channel differences over the first used_chan channels.
  function automatic dist_t color_dist(color_t a, color_t b, int used_chan);
    logic [CHAN_W-1:0]   diff;
    logic [2*CHAN_W-1:0] sq;
    dist_t               sum;
    sum = '0;
    for (int j = 0; j < NUM_CHAN; j++) begin
      diff = (a[j] > b[j]) ? (a[j] - b[j]) : (b[j] - a[j]);
      sq   = diff * diff;
      if (j < used_chan) begin
        sum = sum + DIST_W'(sq);
      end
    end
    return sum;
  endfunction

endpackage

// ===== rtl/npcm_cell.sv =====
// One chain cell: holds a palette entry, scores the passing pixel and keeps the best match.
module npcm_cell import npcm_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int USED_CHAN  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [4:0] palette_size,
  input  flow_t      flow_in,
  output flow_t      flow_out
);

  color_t entry;
  flow_t  a_flow;
  dist_t  a_dist;
  color_t a_color;
  logic   load_hit;
  logic   active;
  logic   take;
  flow_t  flow_next;

  // A load item addressed to this cell replaces the held entry as it passes.
  assign load_hit = flow_in.valid && (flow_in.item.opcode == OP_LOAD) &&
                    (int'(flow_in.item.entry_index) == CELL_INDEX);

  always_ff @(posedge clk) begin
    if (en && load_hit) begin
      entry <= item_color(flow_in.item);
    end
  end

  // First stage: score the pixel against the entry as it stands now, and carry
  // the entry color along so a later load cannot change what this item sees.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_flow.valid <= 1'b0;
    end else if (en) begin
      a_flow.valid <= flow_in.valid;
    end
    if (en) begin
      a_flow.item       <= flow_in.item;
      a_flow.best_d     <= flow_in.best_d;
      a_flow.best_idx   <= flow_in.best_idx;
      a_flow.best_color <= flow_in.best_color;
      a_dist            <= color_dist(entry, item_color(flow_in.item), USED_CHAN);
      a_color           <= entry;
    end
  end

  // Second stage: on a selected map item the first cell always takes; later ones take on a
  // strict improvement, and only when they lie inside the searched part of the palette.
  assign active = (CELL_INDEX == 0) || (int'(palette_size) > CELL_INDEX);
  assign take   = (a_flow.item.opcode == OP_MAP) && a_flow.item.selected &&
                  ((CELL_INDEX == 0) || (active && (a_dist < a_flow.best_d)));

  always_comb begin
    flow_next = a_flow;
    if (take) begin
      flow_next.best_d     = a_dist;
      flow_next.best_idx   = IDX_W'(CELL_INDEX);
      flow_next.best_color = a_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_out <= '0;
    end else if (en) begin
      flow_out <= flow_next;
    end
  end

endmodule

// ===== rtl/nearest_palette_color_mapper.sv =====
// Top level of the nearest palette color mapper: a chain of palette cells and an output register.
//
//   Channel    Handshake             Payload
//   input      in_valid / in_ready   pixel_item  (map or load item)
//   result     out_valid / out_ready result_item (one per map item)
//   config     cfg_we                cfg_data    (palette size)
//
// Every item walks the whole chain, two registers per cell, and then the output register;
// one item enters per cycle while the output register does not stall.
// Load items travel the chain in order with pixels, so a pixel sees exactly the
// loads accepted before it. Load items leave no result.
// A stalled output register holds the whole chain; in_ready is low only then.
// Reset is synchronous; the palette entries are not cleared and must be loaded.
module nearest_palette_color_mapper import npcm_pkg::*; #(
  parameter int PALETTE_DEPTH = 16,
  parameter int CHANNELS      = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  pixel_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t result_item,
  input  logic      cfg_we,
  input  logic [4:0] cfg_data
);

  localparam int USED_CHAN = (CHANNELS < NUM_CHAN) ? CHANNELS : NUM_CHAN;

  logic       en;
  logic [4:0] palette_size;
  flow_t      flows [PALETTE_DEPTH+1];
  flow_t      last;

  // Palette size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= 5'd16;
    end else if (cfg_we) begin
      palette_size <= cfg_data;
    end
  end

  // The chain moves whenever the output register can take what reaches it.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Head of the chain: the incoming item with no match yet.
  assign flows[0].valid      = in_valid;
  assign flows[0].item       = pixel_item;
  assign flows[0].best_d     = '1;
  assign flows[0].best_idx   = '0;
  assign flows[0].best_color = '0;

  // One cell for each palette entry.
  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX (i),
      .USED_CHAN  (USED_CHAN)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .palette_size (palette_size),
      .flow_in      (flows[i]),
      .flow_out     (flows[i+1])
    );
  end

  assign last = flows[PALETTE_DEPTH];

  // Output register: map items become results, selected ones with the palette color.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.valid && (last.item.opcode == OP_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_item.frame_end_out <= last.item.frame_end;
      if (last.item.selected) begin
        result_item.out_chan_0   <= last.best_color[0];
        result_item.out_chan_1   <= last.best_color[1];
        result_item.out_chan_2   <= last.best_color[2];
        result_item.out_chan_3   <= last.best_color[3];
        result_item.chosen_index <= last.best_idx[3:0];
        result_item.written      <= 1'b1;
      end else begin
        result_item.out_chan_0   <= last.item.chan_0;
        result_item.out_chan_1   <= last.item.chan_1;
        result_item.out_chan_2   <= last.item.chan_2;
        result_item.out_chan_3   <= last.item.chan_3;
        result_item.chosen_index <= 4'd0;
        result_item.written      <= 1'b0;
      end
    end
  end

  // A passed-through pixel always reports index zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_item.written |-> result_item.chosen_index == 4'd0)
    else $error("passed-through pixel carries a nonzero index");

  // A load item reaching the end of the chain never produces a result.
  assert property (@(posedge clk) disable iff (rst)
    en && last.valid && (last.item.opcode == OP_LOAD) |=> !out_valid)
    else $error("load item produced a result");

  // A map item reaching the end of the chain always produces a result.
  assert property (@(posedge clk) disable iff (rst)
    en && last.valid && (last.item.opcode == OP_MAP) |=> out_valid)
    else $error("map item was lost at the output");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule
